/* design/pfa_pkg.sv */
// package for the paging frame allocator
// holds opcodes, status codes, pool sizes and the sequencer state type; no dependencies
package pfa_pkg;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_BAD_PID = 2'd2;
    localparam logic [1:0] ST_BAD_ARG = 2'd3;

    localparam int PID_W   = 9;
    localparam int FRAME_W = 10;
    localparam int PAGES_W = 5;

    // pool sizes: every frame number and every process id is in range
    localparam int NUM_FRAMES    = 1024;
    localparam int NUM_PROCESSES = 512;
    localparam int MAX_PAGES     = 30;
    // page map row of 32 slots per process
    localparam int SLOT_W        = 5;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_SEARCH,
        S_POP_RD,
        S_POP_WR,
        S_REM_RD,
        S_REM_WR,
        S_LOOK,
        S_DONE
    } t_state;

endpackage

/* design/pfa_if.sv */
// valid/ready channel interfaces for the paging frame allocator
// request and result channels; depends on pfa_pkg
interface pfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [4:0]                  page_count;
    logic [pfa_pkg::PID_W-1:0]   process_id;
    logic [4:0]                  page_index;
    modport source (output valid, opcode, page_count, process_id, page_index, input ready);
    modport sink   (input valid, opcode, page_count, process_id, page_index, output ready);
endinterface

interface pfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [pfa_pkg::PID_W-1:0]     result_process;
    logic [pfa_pkg::FRAME_W-1:0]   frame_number;
    logic [pfa_pkg::PAGES_W-1:0]   pages_held;
    modport source (output valid, status, result_process, frame_number, pages_held,
                    input ready);
    modport sink   (input valid, status, result_process, frame_number, pages_held,
                    output ready);
endinterface

/* design/pfa_ram.sv */
// generic synchronous ram with one write port and one registered read port
// no dependencies
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/paging_frame_allocator.sv */
// top level of the paging frame allocator
// depends on pfa_pkg, pfa_if and pfa_ram
// Frame pool manager: one request in, one result out, one request worked on
// at a time. After reset a clearing pass over all NUM_FRAMES (1024) entries
// loads the free stack (frame i at entry i) and clears the process table; no
// request is taken meanwhile. A rejected add, a remove or lookup of a dead
// id and a bad opcode go straight from the table read to the result; a
// lookup of a live id adds a step for the page map read. A remove reads the
// page map and pushes each page frame in turn, then pushes the table frame.
// A successful add scans the process table one id per cycle for the lowest
// free id, then pops the table frame and each page frame, every pop a read
// then a write on the free stack. The sequencer goes back to idle, and so
// raises ready again, on the edge that registers the result. The result sits
// in its own output register, so a stalled receiver holds the sequencer only
// when the next result is ready too.
module paging_frame_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_req_if.sink   i_req,
    pfa_rsp_if.source o_rsp
);
    localparam int FA_W   = pfa_pkg::FRAME_W;
    localparam int FC_W   = FA_W + 1;
    localparam int PA_W   = pfa_pkg::PID_W;
    localparam int PC_W   = PA_W + 1;
    localparam int SLOT_W = pfa_pkg::SLOT_W;
    localparam int FW     = pfa_pkg::FRAME_W;
    localparam int PW     = pfa_pkg::PAGES_W;
    localparam int PT_W   = 1 + FW + PW;

    pfa_pkg::t_state r_state, n_state;

    logic [FC_W-1:0]        r_free_count, n_free_count;
    logic [PC_W-1:0]        r_live, n_live;
    logic [FA_W-1:0]        r_cnt, n_cnt;
    logic [1:0]             r_op;
    logic [PW-1:0]          r_count;
    logic [PA_W-1:0]        r_pid_in;
    logic [PW-1:0]          r_idx;
    logic [PA_W-1:0]        r_pid, n_pid;
    logic [SLOT_W-1:0]      r_k, n_k;
    logic [FW-1:0]          r_tf, n_tf;
    logic [PW-1:0]          r_pages, n_pages;
    logic                   r_tab_done, n_tab_done;

    // result being built
    logic [1:0]             r_res_status, n_res_status;
    logic [PA_W-1:0]        r_res_pid, n_res_pid;
    logic [FW-1:0]          r_res_frame, n_res_frame;
    logic [PW-1:0]          r_res_pages, n_res_pages;

    // output register
    logic                   r_o_valid;
    logic [1:0]             r_o_status;
    logic [PA_W-1:0]        r_o_pid;
    logic [FW-1:0]          r_o_frame;
    logic [PW-1:0]          r_o_pages;
    logic                   rsp_load;

    // memory ports
    logic                   fs_we;
    logic [FA_W-1:0]        fs_waddr, fs_raddr;
    logic [FW-1:0]          fs_wdata, fs_rdata;
    logic                   pt_we;
    logic [PA_W-1:0]        pt_addr;
    logic [PT_W-1:0]        pt_wdata, pt_rdata;
    logic                   pm_we;
    logic [PA_W+SLOT_W-1:0] pm_waddr, pm_raddr;
    logic [FW-1:0]          pm_wdata, pm_rdata;

    logic                   entry_live;
    logic                   count_ok;
    logic                   add_ok;
    logic                   pop_last;

    pfa_ram #(.WIDTH(FW), .DEPTH(pfa_pkg::NUM_FRAMES)) u_free_stack (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );
    // process table word: live bit, table frame, page count
    pfa_ram #(.WIDTH(PT_W), .DEPTH(pfa_pkg::NUM_PROCESSES)) u_proc_table (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_addr), .i_wdata(pt_wdata),
        .i_raddr(pt_addr), .o_rdata(pt_rdata)
    );
    pfa_ram #(.WIDTH(FW), .DEPTH(pfa_pkg::NUM_PROCESSES * (2 ** SLOT_W))) u_page_map (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    assign i_req.ready          = (r_state == pfa_pkg::S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.result_process = r_o_pid;
    assign o_rsp.frame_number   = r_o_frame;
    assign o_rsp.pages_held     = r_o_pages;

    // decode of the table entry read last cycle and of the add request
    assign entry_live = pt_rdata[PT_W-1];
    assign count_ok   = (r_count != '0) && (r_count <= PW'(pfa_pkg::MAX_PAGES));
    assign add_ok     = count_ok && (r_free_count > FC_W'(r_count)) &&
                        (r_live < PC_W'(pfa_pkg::NUM_PROCESSES));
    assign pop_last   = r_tab_done && (r_k == SLOT_W'(r_count - 1'b1));
    assign rsp_load   = (r_state == pfa_pkg::S_DONE) && (!r_o_valid || o_rsp.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_INIT: begin
                if (r_cnt == FA_W'(pfa_pkg::NUM_FRAMES - 1)) n_state = pfa_pkg::S_IDLE;
            end
            pfa_pkg::S_IDLE:   if (i_req.valid && i_req.ready) n_state = pfa_pkg::S_READ;
            pfa_pkg::S_READ:   n_state = pfa_pkg::S_DECIDE;
            pfa_pkg::S_DECIDE: begin
                n_state = pfa_pkg::S_DONE;
                case (r_op)
                    pfa_pkg::OP_ADD:    if (add_ok) n_state = pfa_pkg::S_SEARCH;
                    pfa_pkg::OP_REMOVE: if (entry_live) n_state = pfa_pkg::S_REM_RD;
                    pfa_pkg::OP_LOOKUP: if (entry_live) n_state = pfa_pkg::S_LOOK;
                    default: n_state = pfa_pkg::S_DONE;
                endcase
            end
            pfa_pkg::S_SEARCH: if (!entry_live) n_state = pfa_pkg::S_POP_RD;
            pfa_pkg::S_POP_RD: n_state = pfa_pkg::S_POP_WR;
            pfa_pkg::S_POP_WR: begin
                if (pop_last) n_state = pfa_pkg::S_DONE;
                else n_state = pfa_pkg::S_POP_RD;
            end
            pfa_pkg::S_REM_RD: n_state = pfa_pkg::S_REM_WR;
            pfa_pkg::S_REM_WR: if (r_tab_done) n_state = pfa_pkg::S_DONE;
                               else n_state = pfa_pkg::S_REM_RD;
            pfa_pkg::S_LOOK:   n_state = pfa_pkg::S_DONE;
            pfa_pkg::S_DONE:   if (!r_o_valid || o_rsp.ready) n_state = pfa_pkg::S_IDLE;
            default:           n_state = pfa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_free_count = r_free_count;
        n_live       = r_live;
        n_cnt        = r_cnt;
        n_pid        = r_pid;
        n_k          = r_k;
        n_tf         = r_tf;
        n_pages      = r_pages;
        n_tab_done   = r_tab_done;
        n_res_status = r_res_status;
        n_res_pid    = r_res_pid;
        n_res_frame  = r_res_frame;
        n_res_pages  = r_res_pages;
        fs_we        = 1'b0;
        fs_waddr     = r_free_count[FA_W-1:0];
        fs_wdata     = '0;
        fs_raddr     = FA_W'(r_free_count - 1'b1);
        pt_we        = 1'b0;
        pt_addr      = r_pid_in;
        pt_wdata     = '0;
        pm_we        = 1'b0;
        pm_waddr     = {r_pid, r_k};
        pm_wdata     = fs_rdata;
        pm_raddr     = {r_pid_in, SLOT_W'(r_idx)};
        case (r_state)
            pfa_pkg::S_INIT: begin
                // load frame i into entry i and clear the process table
                fs_we    = 1'b1;
                fs_waddr = r_cnt;
                fs_wdata = r_cnt;
                pt_we    = (r_cnt < FA_W'(pfa_pkg::NUM_PROCESSES));
                pt_addr  = r_cnt[PA_W-1:0];
                pt_wdata = '0;
                n_cnt    = r_cnt + 1'b1;
            end
            pfa_pkg::S_DECIDE: begin
                // start the id scan at zero
                pt_addr      = '0;
                n_pid        = '0;
                n_k          = '0;
                n_tab_done   = 1'b0;
                n_pages      = pt_rdata[PW-1:0];
                n_tf         = pt_rdata[FW+PW-1:PW];
                n_res_pid    = r_pid_in;
                n_res_frame  = '0;
                n_res_pages  = '0;
                case (r_op)
                    pfa_pkg::OP_ADD: begin
                        n_res_pid = '0;
                        if (!count_ok) begin
                            n_res_status = pfa_pkg::ST_BAD_ARG;
                        end else begin
                            n_res_status = pfa_pkg::ST_NO_ROOM;
                        end
                    end
                    pfa_pkg::OP_REMOVE: begin
                        n_res_status = pfa_pkg::ST_BAD_PID;
                        n_k          = SLOT_W'(pt_rdata[PW-1:0]);
                        n_tab_done   = (pt_rdata[PW-1:0] == '0);
                        n_pid        = r_pid_in;
                    end
                    pfa_pkg::OP_LOOKUP: n_res_status = pfa_pkg::ST_BAD_PID;
                    default:            n_res_status = pfa_pkg::ST_BAD_ARG;
                endcase
            end
            pfa_pkg::S_SEARCH: begin
                // check id r_pid, read the next one
                pt_addr = r_pid + 1'b1;
                if (entry_live) n_pid = r_pid + 1'b1;
            end
            pfa_pkg::S_POP_RD: begin
                // read top of stack
                fs_raddr     = FA_W'(r_free_count - 1'b1);
                n_free_count = r_free_count - 1'b1;
            end
            pfa_pkg::S_POP_WR: begin
                if (!r_tab_done) begin
                    n_tf       = fs_rdata;
                    n_tab_done = 1'b1;
                end else begin
                    pm_we    = 1'b1;
                    pm_waddr = {r_pid, r_k};
                    pm_wdata = fs_rdata;
                    n_k      = r_k + 1'b1;
                    if (pop_last) begin
                        pt_we        = 1'b1;
                        pt_addr      = r_pid;
                        pt_wdata     = {1'b1, r_tf, r_count};
                        n_live       = r_live + 1'b1;
                        n_res_status = pfa_pkg::ST_OK;
                        n_res_pid    = r_pid;
                        n_res_frame  = r_tf;
                        n_res_pages  = r_count;
                    end
                end
            end
            pfa_pkg::S_REM_RD: begin
                // fetch last remaining page frame
                pm_raddr = {r_pid, SLOT_W'(r_k - 1'b1)};
            end
            pfa_pkg::S_REM_WR: begin
                fs_we        = 1'b1;
                fs_waddr     = r_free_count[FA_W-1:0];
                n_free_count = r_free_count + 1'b1;
                if (r_tab_done) begin
                    fs_wdata     = r_tf;
                    pt_we        = 1'b1;
                    pt_addr      = r_pid;
                    pt_wdata     = '0;
                    n_live       = r_live - 1'b1;
                    n_res_status = pfa_pkg::ST_OK;
                    n_res_frame  = r_tf;
                    n_res_pages  = r_pages;
                end else begin
                    fs_wdata   = pm_rdata;
                    n_k        = r_k - 1'b1;
                    n_tab_done = (r_k == SLOT_W'(1));
                end
            end
            pfa_pkg::S_LOOK: begin
                n_res_pages = r_pages;
                if (r_idx >= r_pages) begin
                    n_res_status = pfa_pkg::ST_BAD_ARG;
                    n_res_frame  = '0;
                end else begin
                    n_res_status = pfa_pkg::ST_OK;
                    n_res_frame  = pm_rdata;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfa_pkg::S_INIT;
            r_free_count <= FC_W'(pfa_pkg::NUM_FRAMES);
            r_live       <= '0;
            r_cnt        <= '0;
            r_o_valid    <= 1'b0;
            r_tab_done   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_live       <= n_live;
            r_cnt        <= n_cnt;
            r_tab_done   <= n_tab_done;
            if (rsp_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pid        <= n_pid;
        r_k          <= n_k;
        r_tf         <= n_tf;
        r_pages      <= n_pages;
        r_res_status <= n_res_status;
        r_res_pid    <= n_res_pid;
        r_res_frame  <= n_res_frame;
        r_res_pages  <= n_res_pages;
        if (rsp_load) begin
            r_o_status <= r_res_status;
            r_o_pid    <= r_res_pid;
            r_o_frame  <= r_res_frame;
            r_o_pages  <= r_res_pages;
        end
        if (i_req.valid && i_req.ready) begin
            r_op     <= i_req.opcode;
            r_count  <= i_req.page_count;
            r_pid_in <= i_req.process_id;
            r_idx    <= i_req.page_index;
        end
    end

    // checks
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pfa_pkg::S_IDLE) |-> !i_req.ready)
        else $error("request taken while busy");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= FC_W'(pfa_pkg::NUM_FRAMES))
        else $error("free count overflow");
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= PC_W'(pfa_pkg::NUM_PROCESSES))
        else $error("live count overflow");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
        (o_rsp.valid && $stable({r_o_status, r_o_pid, r_o_frame, r_o_pages})))
        else $error("result changed while waiting");
endmodule

/* tb/paging_frame_allocator_scoreboard.sv */
// scoreboard for the paging frame allocator testbench
// holds a predictor of the frame pool and a queue of expected results; depends on pfa_pkg
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]                    status;
    logic [pfa_pkg::PID_W-1:0]     result_process;
    logic [pfa_pkg::FRAME_W-1:0]   frame_number;
    logic [pfa_pkg::PAGES_W-1:0]   pages_held;
} t_alloc_result;

class frame_pool_scoreboard;
    localparam int N_FRAMES = 1024;
    localparam int N_PROCS  = 512;
    localparam int PAGE_MAX = 30;

    bit [9:0]      free_stack [N_FRAMES];
    int            free_count;
    bit            proc_live [N_PROCS];
    bit [9:0]      proc_table [N_PROCS];
    bit [4:0]      proc_pages [N_PROCS];
    bit [9:0]      proc_frames [N_PROCS][32];
    int            live_count;
    t_alloc_result pending_results [$];
    int            errors;

    function new();
        for (int i = 0; i < N_FRAMES; i++) free_stack[i] = i[9:0];
        free_count = N_FRAMES;
        for (int i = 0; i < N_PROCS; i++) proc_live[i] = 0;
        live_count = 0;
        errors = 0;
    endfunction

    function bit [9:0] pop_frame();
        free_count--;
        return free_stack[free_count];
    endfunction

    function void push_frame(bit [9:0] f);
        if (free_count < N_FRAMES) begin
            free_stack[free_count] = f;
            free_count++;
        end
    endfunction

    // lowest free id, or -1 when all are taken
    function int lowest_free_pid();
        for (int p = 0; p < N_PROCS; p++)
            if (!proc_live[p]) return p;
        return -1;
    endfunction

    // predict the result of one accepted request and update the pool
    function void note_request(logic [1:0] op, logic [4:0] cnt, logic [8:0] pid,
                               logic [4:0] idx);
        t_alloc_result r;
        int p;
        r = '{status: pfa_pkg::ST_BAD_ARG, result_process: pid, frame_number: '0,
              pages_held: '0};
        if (op == pfa_pkg::OP_ADD) begin
            r.result_process = '0;
            p = lowest_free_pid();
            if (cnt == 0 || cnt > PAGE_MAX) begin
                r.status = pfa_pkg::ST_BAD_ARG;
            end else if (free_count < cnt + 1 || live_count >= N_PROCS || p < 0) begin
                r.status = pfa_pkg::ST_NO_ROOM;
            end else begin
                proc_table[p] = pop_frame();
                for (int k = 0; k < cnt; k++) proc_frames[p][k] = pop_frame();
                proc_live[p] = 1;
                proc_pages[p] = cnt;
                live_count++;
                r = '{status: pfa_pkg::ST_OK, result_process: p[8:0],
                      frame_number: proc_table[p], pages_held: cnt};
            end
        end else if (op == pfa_pkg::OP_REMOVE || op == pfa_pkg::OP_LOOKUP) begin
            if (!proc_live[pid]) begin
                r.status = pfa_pkg::ST_BAD_PID;
            end else if (op == pfa_pkg::OP_REMOVE) begin
                for (int k = proc_pages[pid]; k > 0; k--) push_frame(proc_frames[pid][k-1]);
                push_frame(proc_table[pid]);
                proc_live[pid] = 0;
                live_count--;
                r = '{status: pfa_pkg::ST_OK, result_process: pid,
                      frame_number: proc_table[pid], pages_held: proc_pages[pid]};
            end else if (idx >= proc_pages[pid]) begin
                r.status = pfa_pkg::ST_BAD_ARG;
                r.pages_held = proc_pages[pid];
            end else begin
                r = '{status: pfa_pkg::ST_OK, result_process: pid,
                      frame_number: proc_frames[pid][idx], pages_held: proc_pages[pid]};
            end
        end
        pending_results.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(t_alloc_result act);
        t_alloc_result exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, act);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        if (act.status !== exp_r.status) begin
            $display("%0t: status exp %0d act %0d", $time, exp_r.status, act.status);
            errors++;
        end
        if (act.result_process !== exp_r.result_process) begin
            $display("%0t: result_process exp %0d act %0d", $time,
                     exp_r.result_process, act.result_process);
            errors++;
        end
        if (act.frame_number !== exp_r.frame_number) begin
            $display("%0t: frame_number exp %0d act %0d", $time,
                     exp_r.frame_number, act.frame_number);
            errors++;
        end
        if (act.pages_held !== exp_r.pages_held) begin
            $display("%0t: pages_held exp %0d act %0d", $time,
                     exp_r.pages_held, act.pages_held);
            errors++;
        end
    endfunction
endclass

/* tb/paging_frame_allocator_test.sv */
// testbench top for the paging frame allocator
// drives requests with random gaps and checks results; depends on pfa_pkg, pfa_if, scoreboard
`timescale 1ns / 1ps

module paging_frame_allocator_test;

    localparam int CYCLE_LIMIT = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    paging_frame_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    frame_pool_scoreboard pool_sb;
    int  cycle_count;
    bit  hold_off;
    bit  sending_done;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** paging_frame_allocator: FAILED **");
            $finish;
        end
    end

    // short gaps mostly, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one request and wait for acceptance; valid stays up until the
    // next request or a gap replaces it
    task automatic send_request(logic [1:0] op, logic [4:0] cnt, logic [8:0] pid,
                                logic [4:0] idx);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.page_count <= cnt;
        req_ch.process_id <= pid;
        req_ch.page_index <= idx;
        do @(posedge i_clk); while (!(req_ch.ready === 1'b1));
        pool_sb.note_request(op, cnt, pid, idx);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0) req_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // pick a live pid most of the time, else any
    function automatic logic [8:0] some_pid();
        int tries;
        logic [8:0] p;
        for (tries = 0; tries < 20; tries++) begin
            p = 9'($urandom_range(0, 40));
            if (pool_sb.proc_live[p]) return p;
        end
        return 9'($urandom_range(0, 511));
    endfunction

    // receiver side: random ready, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // result sampling
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            pool_sb.check_result('{status: rsp_ch.status,
                                   result_process: rsp_ch.result_process,
                                   frame_number: rsp_ch.frame_number,
                                   pages_held: rsp_ch.pages_held});
    end

    // long receiver stall in its own process
    initial begin
        hold_off = 1'b0;
        wait (sending_done == 1'b0 && cycle_count > 3000);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // stimulus
    initial begin
        int op_pick;
        pool_sb = new();
        cycle_count = 0;
        sending_done = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = pfa_pkg::OP_ADD;
        req_ch.page_count = '0;
        req_ch.process_id = '0;
        req_ch.page_index = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every operation and special case
        send_request(pfa_pkg::OP_ADD, 5'd0, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_ADD, 5'd31, 9'h1ff, 5'd31);
        send_request(pfa_pkg::OP_ADD, 5'd1, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_ADD, 5'd30, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'd0, 5'd1);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'd1, 5'd29);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'd1, 5'd30);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'd1, 5'd31);
        send_request(pfa_pkg::OP_LOOKUP, 5'd0, 9'h1ff, 5'd0);
        send_request(pfa_pkg::OP_REMOVE, 5'd0, 9'd5, 5'd0);
        send_request(pfa_pkg::OP_RESERVED, 5'd31, 9'h1ff, 5'd31);
        send_request(pfa_pkg::OP_REMOVE, 5'd0, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_ADD, 5'd2, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_REMOVE, 5'd0, 9'd1, 5'd0);
        send_request(pfa_pkg::OP_REMOVE, 5'd0, 9'd1, 5'd0);
        // fill the pool until no room
        repeat (34) send_request(pfa_pkg::OP_ADD, 5'd30, 9'd0, 5'd0);
        send_request(pfa_pkg::OP_ADD, 5'd1, 9'd0, 5'd0);
        for (int p = 0; p < 40; p++) send_request(pfa_pkg::OP_REMOVE, 5'd0, p[8:0], 5'd0);

        // random: mostly well-formed adds, removes and lookups
        for (int n = 0; n < 1200; n++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 38)
                send_request(pfa_pkg::OP_ADD, 5'($urandom_range(1, 30)), 9'($urandom),
                             5'($urandom));
            else if (op_pick < 60)
                send_request(pfa_pkg::OP_REMOVE, 5'($urandom), some_pid(), 5'($urandom));
            else if (op_pick < 92)
                send_request(pfa_pkg::OP_LOOKUP, 5'($urandom), some_pid(), 5'($urandom));
            else
                send_request(2'($urandom), 5'($urandom), 9'($urandom), 5'($urandom));
            if (n % 300 < 200) idle_gap();
        end
        req_ch.valid <= 1'b0;
        sending_done = 1'b1;

        // drain
        while (pool_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (pool_sb.errors == 0 && pool_sb.pending_results.size() == 0)
            $display("** paging_frame_allocator: PASSED **");
        else
            $display("** paging_frame_allocator: FAILED **");
        $finish;
    end
endmodule
